[rtl/iem_pkg.sv]
// Shared types and constants for the image error metrics unit.
package iem_pkg;

    // Largest side length used for the pixel count
    localparam logic [12:0] MAX_SIDE = 13'd4096;

    // Saturation limits
    localparam logic [42:0] ACC_MAX  = {43{1'b1}};
    localparam logic [25:0] MSE_MAX  = {26{1'b1}};
    localparam logic [33:0] PMSE_MAX = {34{1'b1}};
    localparam logic [15:0] DB_POS_MAX = 16'h7FFF;
    localparam logic [15:0] DB_NEG_MIN = 16'h8000;

    // 10*log10(2) in Q.16
    localparam logic [31:0] DB_SCALE = 32'd197283;

    // Divider widths
    localparam int DIV_NUM_W = 60;
    localparam int DIV_DEN_W = 42;

    // Configuration register indexes
    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;

    // Log operand selection
    typedef enum logic [1:0] {
        LOG_SIGNAL,
        LOG_ERROR,
        LOG_PEAK
    } log_sel_t;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_N,
        ST_MUL_PP,
        ST_MUL_PPN,
        ST_SAVE_PPN,
        ST_LOG_LOAD,
        ST_LOG_NORM,
        ST_LOG_SQ,
        ST_LOG_FIX,
        ST_DB_MUL,
        ST_DB_RND,
        ST_DIV_MSE_GO,
        ST_DIV_MSE_WAIT,
        ST_DIV_PMSE_GO,
        ST_DIV_PMSE_WAIT,
        ST_FINISH
    } state_t;

endpackage

[rtl/iem_divider.sv]
// Restoring bit-serial divider, one quotient bit per cycle.
module iem_divider
    import iem_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [DIV_NUM_W-1:0] numer,
    input  logic [DIV_DEN_W-1:0] denom,
    output logic                 done,
    output logic [DIV_NUM_W-1:0] quot
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [5:0]           cnt_reg;
    logic [DIV_NUM_W-1:0] q_reg;
    logic [DIV_DEN_W-1:0] den_reg;
    logic [DIV_DEN_W:0]   rem_reg;
    logic [DIV_DEN_W:0]   rem_shift;
    logic                 fits;

    // One restoring step
    assign rem_shift = {rem_reg[DIV_DEN_W-1:0], q_reg[DIV_NUM_W-1]};
    assign fits      = rem_shift >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'(DIV_NUM_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= numer;
            den_reg <= denom;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? rem_shift - {1'b0, den_reg} : rem_shift;
            q_reg   <= {q_reg[DIV_NUM_W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

[rtl/image_error_metrics_unit.sv]
// Image error metrics: MSE, PMSE, SNR, PSNR and max difference over a sample stream.
//
// Reference and test samples are accepted one per cycle while the block is
// idle and folded into saturating sums of squared error and squared
// reference, plus the peak reference sample and the largest difference. The
// transaction with tlast set closes the image pair: the block then drops
// tready and a sequencer drives one shared 32x32 multiplier (pixel count,
// peak^2*N, sixteen squarings per log2, dB scaling) and a bit-serial divider
// (MSE and PMSE). Three log2 evaluations each load the operand, normalize it
// and square the mantissa; wide sums normalize faster and a zero peak skips
// the PMSE division. The result stays in an output register, so samples of
// the next image are taken while it waits.
module image_error_metrics_unit
    import iem_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    // Configuration writes
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [12:0]  cfg_data,
    // Sample stream
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [15:0]  s_axis_tdata,   // ref_sample[7:0], test_sample[15:8]
    input  logic         s_axis_tlast,   // last_sample
    // Result stream
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [103:0] m_axis_tdata    // mse[25:0], pmse[59:26], snr_db[75:60],
                                         // psnr_db[91:76], max_diff[99:92], status[101:100]
);

    state_t state_reg, state_next;

    logic [12:0] width_reg, height_reg;
    logic [42:0] err_reg, sig_reg;
    logic [7:0]  peak_reg, maxd_reg;

    logic [63:0] prod_reg;
    logic [31:0] mul_a, mul_b;

    logic [25:0] n_reg;
    logic [41:0] ppn_reg;

    log_sel_t    log_sel_reg;
    logic [63:0] x_reg;
    logic [5:0]  lgn_reg;
    logic [31:0] m_reg;
    logic [15:0] frac_reg;
    logic [3:0]  it_reg;
    logic [21:0] lg_s_reg, lg_e_reg, lg_p_reg;

    logic        db_psnr_reg;
    logic        db_neg_reg;
    logic [15:0] snr_reg, psnr_reg;
    logic [25:0] mse_reg;
    logic [33:0] pmse_reg;

    logic        out_valid_reg;
    logic [103:0] out_data_reg;

    logic        in_fire;
    logic [7:0]  r_s, t_s, d_s;
    logic [43:0] err_sum, sig_sum;
    logic [12:0] side_w, side_h;
    logic [42:0] log_op;
    logic [32:0] sq_t;
    logic [15:0] frac_new;
    logic [22:0] lg_diff;
    logic [21:0] lg_mag;
    logic [16:0] db_r;
    logic [15:0] db_val;

    logic                 div_start;
    logic [DIV_NUM_W-1:0] div_num;
    logic [DIV_DEN_W-1:0] div_den;
    logic                 div_done;
    logic [DIV_NUM_W-1:0] div_q;

    logic [15:0] snr_out, psnr_out;
    logic [1:0]  status_out;
    logic        finish_go;

    // Handshakes
    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 13'd1;
            height_reg <= 13'd1;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_WIDTH:  width_reg  <= cfg_data;
                REG_HEIGHT: height_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    // Clamped sides
    assign side_w = (width_reg == 13'd0) ? 13'd1 :
                    (width_reg > MAX_SIDE) ? MAX_SIDE : width_reg;
    assign side_h = (height_reg == 13'd0) ? 13'd1 :
                    (height_reg > MAX_SIDE) ? MAX_SIDE : height_reg;

    // Per-sample accumulation
    assign r_s     = s_axis_tdata[7:0];
    assign t_s     = s_axis_tdata[15:8];
    assign d_s     = (r_s >= t_s) ? r_s - t_s : t_s - r_s;
    assign err_sum = {1'b0, err_reg} + 44'({8'd0, d_s} * {8'd0, d_s});
    assign sig_sum = {1'b0, sig_reg} + 44'({8'd0, r_s} * {8'd0, r_s});
    assign finish_go = (state_reg == ST_FINISH) && (!out_valid_reg || m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            err_reg  <= '0;
            sig_reg  <= '0;
            peak_reg <= '0;
            maxd_reg <= '0;
        end
        else if (finish_go)
        begin
            err_reg  <= '0;
            sig_reg  <= '0;
            peak_reg <= '0;
            maxd_reg <= '0;
        end
        else if (in_fire)
        begin
            err_reg <= (err_sum > {1'b0, ACC_MAX}) ? ACC_MAX : err_sum[42:0];
            sig_reg <= (sig_sum > {1'b0, ACC_MAX}) ? ACC_MAX : sig_sum[42:0];
            if (r_s > peak_reg)
                peak_reg <= r_s;
            if (d_s > maxd_reg)
                maxd_reg <= d_s;
        end
    end

    // Shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_MUL_N:
            begin
                mul_a = 32'(side_w);
                mul_b = 32'(side_h);
            end
            ST_MUL_PP:
            begin
                mul_a = 32'(peak_reg);
                mul_b = 32'(peak_reg);
            end
            ST_MUL_PPN:
            begin
                mul_a = {16'd0, prod_reg[15:0]};
                mul_b = 32'(n_reg);
            end
            ST_LOG_SQ:
            begin
                mul_a = m_reg;
                mul_b = m_reg;
            end
            ST_DB_MUL:
            begin
                mul_a = 32'(lg_mag);
                mul_b = DB_SCALE;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
    end

    // Log and dB helpers
    always_comb
    begin
        case (log_sel_reg)
            LOG_SIGNAL: log_op = sig_reg;
            LOG_ERROR:  log_op = err_reg;
            default:    log_op = {1'b0, ppn_reg};
        endcase
    end

    assign sq_t     = prod_reg[63:31];
    assign frac_new = {frac_reg[14:0], sq_t[32]};
    assign lg_diff  = (db_psnr_reg ? {1'b0, lg_p_reg} : {1'b0, lg_s_reg}) - {1'b0, lg_e_reg};
    assign lg_mag   = lg_diff[22] ? 22'(-lg_diff) : lg_diff[21:0];
    assign db_r     = 17'((prod_reg[39:0] + 40'h80_0000) >> 24);

    always_comb
    begin
        if (db_neg_reg)
            db_val = (db_r > 17'd32768) ? DB_NEG_MIN : 16'(-db_r);
        else
            db_val = (db_r > 17'd32767) ? DB_POS_MAX : db_r[15:0];
    end

    // Divider operands
    assign div_start = (state_reg == ST_DIV_MSE_GO) || (state_reg == ST_DIV_PMSE_GO);
    assign div_num   = (state_reg == ST_DIV_MSE_GO) ?
                       DIV_NUM_W'({err_reg, 8'd0}) + DIV_NUM_W'(n_reg >> 1) :
                       DIV_NUM_W'({err_reg, 16'd0}) + DIV_NUM_W'(ppn_reg >> 1);
    assign div_den   = (state_reg == ST_DIV_MSE_GO) ? DIV_DEN_W'(n_reg) : ppn_reg;

    iem_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .numer (div_num),
        .denom (div_den),
        .done  (div_done),
        .quot  (div_q)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:          if (in_fire && s_axis_tlast) state_next = ST_MUL_N;
            ST_MUL_N:         state_next = ST_MUL_PP;
            ST_MUL_PP:        state_next = ST_MUL_PPN;
            ST_MUL_PPN:       state_next = ST_SAVE_PPN;
            ST_SAVE_PPN:      state_next = ST_LOG_LOAD;
            ST_LOG_LOAD:      state_next = ST_LOG_NORM;
            ST_LOG_NORM:      if (x_reg[63]) state_next = ST_LOG_SQ;
            ST_LOG_SQ:        state_next = ST_LOG_FIX;
            ST_LOG_FIX:
            begin
                if (it_reg != 4'd15)
                    state_next = ST_LOG_SQ;
                else if (log_sel_reg == LOG_PEAK)
                    state_next = ST_DB_MUL;
                else
                    state_next = ST_LOG_LOAD;
            end
            ST_DB_MUL:        state_next = ST_DB_RND;
            ST_DB_RND:        state_next = db_psnr_reg ? ST_DIV_MSE_GO : ST_DB_MUL;
            ST_DIV_MSE_GO:    state_next = ST_DIV_MSE_WAIT;
            ST_DIV_MSE_WAIT:
            begin
                if (div_done)
                    state_next = (peak_reg == 8'd0) ? ST_FINISH : ST_DIV_PMSE_GO;
            end
            ST_DIV_PMSE_GO:   state_next = ST_DIV_PMSE_WAIT;
            ST_DIV_PMSE_WAIT: if (div_done) state_next = ST_FINISH;
            ST_FINISH:        if (finish_go) state_next = ST_IDLE;
            default:          state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Sequencer datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_MUL_N:
            begin
                log_sel_reg <= LOG_SIGNAL;
                db_psnr_reg <= 1'b0;
                pmse_reg    <= PMSE_MAX;
            end
            ST_MUL_PP:   n_reg   <= prod_reg[25:0];
            ST_SAVE_PPN: ppn_reg <= prod_reg[41:0];
            ST_LOG_LOAD:
            begin
                x_reg   <= (log_op == 43'd0) ? 64'h8000_0000_0000_0000 : {21'd0, log_op};
                lgn_reg <= 6'd63;
            end
            ST_LOG_NORM:
            begin
                if (x_reg[63])
                begin
                    m_reg    <= x_reg[63:32];
                    it_reg   <= 4'd0;
                    frac_reg <= '0;
                end
                else
                begin
                    x_reg   <= {x_reg[62:0], 1'b0};
                    lgn_reg <= lgn_reg - 6'd1;
                end
            end
            ST_LOG_FIX:
            begin
                m_reg    <= sq_t[32] ? sq_t[32:1] : sq_t[31:0];
                frac_reg <= frac_new;
                it_reg   <= it_reg + 4'd1;
                if (it_reg == 4'd15)
                begin
                    case (log_sel_reg)
                        LOG_SIGNAL:
                        begin
                            lg_s_reg    <= {lgn_reg, frac_new};
                            log_sel_reg <= LOG_ERROR;
                        end
                        LOG_ERROR:
                        begin
                            lg_e_reg    <= {lgn_reg, frac_new};
                            log_sel_reg <= LOG_PEAK;
                        end
                        default: lg_p_reg <= {lgn_reg, frac_new};
                    endcase
                end
            end
            ST_DB_MUL: db_neg_reg <= lg_diff[22];
            ST_DB_RND:
            begin
                if (db_psnr_reg)
                    psnr_reg <= db_val;
                else
                    snr_reg <= db_val;
                db_psnr_reg <= 1'b1;
            end
            ST_DIV_MSE_WAIT:
                if (div_done)
                    mse_reg <= (div_q > DIV_NUM_W'(MSE_MAX)) ? MSE_MAX : div_q[25:0];
            ST_DIV_PMSE_WAIT:
                if (div_done)
                    pmse_reg <= (div_q > DIV_NUM_W'(PMSE_MAX)) ? PMSE_MAX : div_q[33:0];
            default: ;
        endcase
    end

    // Special cases for the result
    always_comb
    begin
        status_out = {peak_reg == 8'd0, err_reg == 43'd0};
        if (err_reg == 43'd0)
        begin
            snr_out  = DB_POS_MAX;
            psnr_out = DB_POS_MAX;
        end
        else
        begin
            snr_out  = (sig_reg == 43'd0) ? DB_NEG_MIN : snr_reg;
            psnr_out = (peak_reg == 8'd0) ? DB_NEG_MIN : psnr_reg;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (finish_go)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (finish_go)
            out_data_reg <= {2'b00, status_out, maxd_reg, psnr_out, snr_out,
                             pmse_reg, mse_reg};
    end

endmodule

[sim/image_error_metrics_unit_test.sv]
// Self-checking testbench for the image error metrics unit, with directed and random image pairs.
module image_error_metrics_unit_test;
    import iem_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // One metrics result transaction, split into its fields
    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  max_diff;
        logic [15:0] psnr_db;
        logic [15:0] snr_db;
        logic [33:0] pmse;
        logic [25:0] mse;
    } metrics_t;

    logic         clk;
    logic         rst_n;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [1:0]   cfg_index;
    logic [12:0]  cfg_data;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [15:0]  s_axis_tdata;
    logic         s_axis_tlast;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [103:0] m_axis_tdata;

    // Predictor state
    logic [12:0]     width_reg;
    logic [12:0]     height_reg;
    longint unsigned err_sum;
    longint unsigned sig_sum;
    logic [7:0]      peak_ref;
    logic [7:0]      max_delta;

    metrics_t        metrics_q[$];
    int              send_idle_pct;
    int              recv_stall_pct;
    int              error_count;
    longint          cycle_count;

    localparam longint CYCLE_LIMIT = 2000000;
    localparam int     DRAIN_CYCLES = 700;

    image_error_metrics_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // ref_sample[7:0], test_sample[15:8]
        .s_axis_tlast  (s_axis_tlast),   // last_sample
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)    // mse, pmse, snr_db, psnr_db, max_diff, status
    );

    // Clock
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Result sink with random stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Compare each result transaction with the oldest prediction
    always @(posedge clk)
    begin
        metrics_t got;
        metrics_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = metrics_t'(m_axis_tdata[101:0]);
            if (metrics_q.size() == 0)
            begin
                $display("%t: unexpected result %h", $realtime, m_axis_tdata);
                error_count++;
            end
            else
            begin
                want = metrics_q.pop_front();
                if (got.mse != want.mse)
                begin
                    $display("%t: mse exp %0d got %0d", $realtime, want.mse, got.mse);
                    error_count++;
                end
                if (got.pmse != want.pmse)
                begin
                    $display("%t: pmse exp %0d got %0d", $realtime, want.pmse, got.pmse);
                    error_count++;
                end
                if (got.snr_db != want.snr_db)
                begin
                    $display("%t: snr_db exp %0d got %0d", $realtime,
                             $signed(want.snr_db), $signed(got.snr_db));
                    error_count++;
                end
                if (got.psnr_db != want.psnr_db)
                begin
                    $display("%t: psnr_db exp %0d got %0d", $realtime,
                             $signed(want.psnr_db), $signed(got.psnr_db));
                    error_count++;
                end
                if (got.max_diff != want.max_diff)
                begin
                    $display("%t: max_diff exp %0d got %0d", $realtime,
                             want.max_diff, got.max_diff);
                    error_count++;
                end
                if (got.status != want.status)
                begin
                    $display("%t: status exp %0d got %0d", $realtime, want.status, got.status);
                    error_count++;
                end
            end
        end
    end

    // log2 in Q.16 by repeated squaring of the normalized mantissa
    function automatic longint unsigned log2_q16(longint unsigned x);
        int              top;
        longint unsigned m;
        longint unsigned frac;
        top = 0;
        frac = 0;
        for (int i = 0; i < 64; i++)
            if (x[i])
                top = i;
        m = (top >= 31) ? (x >> (top - 31)) : (x << (31 - top));
        for (int i = 0; i < 16; i++)
        begin
            m = (m * m) >> 31;
            frac = frac << 1;
            if (m >= 64'h1_0000_0000)
            begin
                frac = frac | 1;
                m = m >> 1;
            end
        end
        return (longint'(top) << 16) | frac;
    endfunction

    // 10*log10(num/den) in Q8.8, saturating
    function automatic logic [15:0] decibels(longint unsigned num, longint unsigned den);
        longint          diff;
        longint unsigned mag;
        longint unsigned r;
        diff = longint'(log2_q16(num)) - longint'(log2_q16(den));
        mag = (diff < 0) ? -diff : diff;
        r = (mag * DB_SCALE + (64'd1 << 23)) >> 24;
        if (diff < 0)
            return (r > 32768) ? DB_NEG_MIN : 16'(-longint'(r));
        return (r > 32767) ? DB_POS_MAX : 16'(r);
    endfunction

    function automatic longint unsigned clamp_side(logic [12:0] v);
        if (v == 0)
            return 1;
        if (v > MAX_SIDE)
            return MAX_SIDE;
        return v;
    endfunction

    // Fold one accepted sample into the predicted sums; close the image on last
    task automatic predict_sample(logic [7:0] r, logic [7:0] t, logic last);
        logic [7:0]      d;
        longint unsigned n;
        longint unsigned p;
        longint unsigned q;
        metrics_t        res;
        d = (r >= t) ? r - t : t - r;
        err_sum = err_sum + d * d;
        if (err_sum > ACC_MAX)
            err_sum = ACC_MAX;
        sig_sum = sig_sum + r * r;
        if (sig_sum > ACC_MAX)
            sig_sum = ACC_MAX;
        if (r > peak_ref)
            peak_ref = r;
        if (d > max_delta)
            max_delta = d;
        if (!last)
            return;
        n = clamp_side(width_reg) * clamp_side(height_reg);
        p = peak_ref;
        res = '0;
        q = (err_sum * 256 + n / 2) / n;
        res.mse = (q > MSE_MAX) ? MSE_MAX : q[25:0];
        if (p == 0)
        begin
            res.pmse = PMSE_MAX;
            res.status[1] = 1'b1;
        end
        else
        begin
            q = (err_sum * 65536 + (n * p * p) / 2) / (n * p * p);
            res.pmse = (q > PMSE_MAX) ? PMSE_MAX : q[33:0];
        end
        if (err_sum == 0)
        begin
            res.status[0] = 1'b1;
            res.snr_db = DB_POS_MAX;
            res.psnr_db = DB_POS_MAX;
        end
        else
        begin
            res.snr_db = (sig_sum == 0) ? DB_NEG_MIN : decibels(sig_sum, err_sum);
            res.psnr_db = (p == 0) ? DB_NEG_MIN : decibels(p * p * n, err_sum);
        end
        res.max_diff = max_delta;
        metrics_q.push_back(res);
        err_sum = 0;
        sig_sum = 0;
        peak_ref = 0;
        max_delta = 0;
    endtask

    // Send one sample transaction; called and returns at a rising edge
    task automatic send_sample(logic [7:0] r, logic [7:0] t, logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {t, r};
        s_axis_tlast  <= last;
        do
            @(negedge clk);
        while (!s_axis_tready);
        @(posedge clk);
        predict_sample(r, t, last);
    endtask

    // Stop sending and wait until all results are in and the block is quiet
    task automatic drain;
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (metrics_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // One register write transaction; called and returns at a rising edge
    task automatic write_reg(logic [1:0] idx, logic [12:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(negedge clk);
        while (!cfg_ready);
        @(posedge clk);
        if (idx == REG_WIDTH)
            width_reg = value;
        else if (idx == REG_HEIGHT)
            height_reg = value;
    endtask

    task automatic set_size(logic [12:0] w, logic [12:0] h);
        drain();
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Single-sample images at reset size: every status code and both dB signs
    task automatic test_single_pixel;
        send_sample(8'd255, 8'd0, 1'b1);
        send_sample(8'd0, 8'd0, 1'b1);
        send_sample(8'd200, 8'd200, 1'b1);
        send_sample(8'd0, 8'd77, 1'b1);
        send_sample(8'd255, 8'd255, 1'b1);
        send_sample(8'd3, 8'd250, 1'b1);
        send_sample(8'd128, 8'd127, 1'b1);
    endtask

    // MSE and PMSE saturation on a 1x1 image with a tiny peak
    task automatic test_saturation;
        for (int i = 0; i < 5; i++)
            send_sample(8'd255, 8'd0, i == 4);
        for (int i = 0; i < 5; i++)
            send_sample(8'd1, 8'd255, i == 4);
    endtask

    // Zero and oversized dimensions, ignored indexes, largest image size
    task automatic test_dimension_limits;
        set_size(13'd0, 13'd8191);
        send_sample(8'd10, 8'd20, 1'b0);
        send_sample(8'd90, 8'd30, 1'b1);
        drain();
        write_reg(2'd2, 13'd5);
        write_reg(2'd3, 13'd7);
        cfg_valid <= 1'b0;
        @(posedge clk);
        send_sample(8'd255, 8'd254, 1'b1);
        set_size(13'd4096, 13'd4096);
        send_sample(8'd255, 8'd0, 1'b0);
        send_sample(8'd1, 8'd2, 1'b1);
        send_sample(8'd0, 8'd0, 1'b0);
        send_sample(8'd0, 8'd1, 1'b1);
        set_size(13'd4097, 13'd1);
        send_sample(8'd64, 8'd0, 1'b1);
    endtask

    // Random images of random length under one idling pattern
    task automatic test_random_images(int idle_pct, int stall_pct, int samples);
        int          sent;
        int          len;
        int          kind;
        logic [7:0]  r;
        logic [7:0]  t;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        sent = 0;
        while (sent < samples)
        begin
            len = ($urandom_range(15) == 0) ? $urandom_range(200, 60) : $urandom_range(30, 1);
            kind = $urandom_range(9);
            for (int i = 0; i < len; i++)
            begin
                r = 8'($urandom);
                t = 8'($urandom);
                if (kind == 0)
                    t = r;
                else if (kind == 1)
                    r = 8'd0;
                else if (kind == 2)
                    t = r ^ 8'($urandom_range(3));
                send_sample(r, t, i == len - 1);
            end
            sent += len;
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        error_count = 0;
        cycle_count = 0;
        width_reg = 13'd1;
        height_reg = 13'd1;
        err_sum = 0;
        sig_sum = 0;
        peak_ref = 0;
        max_delta = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_single_pixel();
        test_saturation();
        test_dimension_limits();

        set_size(13'd1, 13'd1);
        test_random_images(0, 0, 280);
        set_size(13'($urandom_range(64, 1)), 13'($urandom_range(64, 1)));
        test_random_images(55, 0, 270);
        set_size(13'($urandom_range(8191)), 13'($urandom_range(20, 1)));
        test_random_images(0, 55, 270);
        set_size(13'($urandom_range(8191)), 13'($urandom_range(8191)));
        test_random_images(23, 23, 280);

        drain();
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

[image_error_metrics_unit.f]
rtl/iem_pkg.sv
rtl/iem_divider.sv
rtl/image_error_metrics_unit.sv
sim/image_error_metrics_unit_test.sv
